### rtl/sldf_pkg.sv
// shared types and constants of the sync length checksum deframer
`default_nettype none
package sldf_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'hFF;
   localparam logic [7:0] HDR_SECOND = 8'hCC;

   localparam logic [7:0] RESET_RESPONSE_CODE = 8'd1;
   localparam logic [7:0] RESET_VOLTAGE_CODE  = 8'd2;
   localparam logic [7:0] RESET_ENCODER_CODE  = 8'd3;

   localparam int unsigned ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_RESPONSE = 2'd0,
      REG_VOLTAGE  = 2'd1,
      REG_ENCODER  = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_SHORT    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_VOLTAGE = 2'd0,
      KIND_ENCODER = 2'd1,
      KIND_OTHER   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] response_code;
      logic [7:0] voltage_code;
      logic [7:0] encoder_code;
   } codes_type;

   typedef struct packed {
      status_type      status;
      logic [7:0]      func_code;
      logic [7:0]      frame_len;
      kind_type        kind;
      logic [15:0]     voltage_mv;
      logic [3:0][7:0] enc;
   } result_type;

endpackage
`default_nettype wire

### rtl/sldf_csr.sv
// configuration registers holding the three function codes
`default_nettype none
module sldf_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sldf_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready,
   output sldf_pkg::codes_type               codes
);
   import sldf_pkg::*;

   codes_type     codes_ff;
   codes_type     codes_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign codes  = codes_ff;

   always_comb begin
      codes_in = codes_ff;
      if (wr_en) begin
         case (index)
            REG_RESPONSE: codes_in.response_code = pwdata[7:0];
            REG_VOLTAGE:  codes_in.voltage_code  = pwdata[7:0];
            REG_ENCODER:  codes_in.encoder_code  = pwdata[7:0];
            default:      codes_in = codes_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_RESPONSE: prdata = {24'd0, codes_ff.response_code};
         REG_VOLTAGE:  prdata = {24'd0, codes_ff.voltage_code};
         REG_ENCODER:  prdata = {24'd0, codes_ff.encoder_code};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.response_code <= RESET_RESPONSE_CODE;
         codes_ff.voltage_code  <= RESET_VOLTAGE_CODE;
         codes_ff.encoder_code  <= RESET_ENCODER_CODE;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule
`default_nettype wire

### rtl/sldf_parser.sv
// per-byte frame state machine: header hunt, length, body, checksum, short frame
`default_nettype none
module sldf_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           rx_byte,
   input  wire sldf_pkg::codes_type  codes,
   output logic                      emit,
   output sldf_pkg::result_type      result
);
   import sldf_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_LEN   = 3'd2,
      PH_BODY  = 3'd3,
      PH_CSUM  = 3'd4,
      PH_SHORT = 3'd5
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [7:0]      len_ff, len_in;
   logic [7:0]      seen_ff, seen_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      func_ff, func_in;
   logic [3:0][7:0] data_ff, data_in;
   logic [7:0]      seen_dec;
   logic [8:0]      seen_plus2;
   status_type      csum_status;
   kind_type        csum_kind;

   assign seen_dec   = seen_ff - 8'd1;
   assign seen_plus2 = {1'b0, seen_ff} + 9'd2;

   always_comb begin
      if (rx_byte == sum_ff) csum_status = ST_GOOD;
      else                   csum_status = ST_MISMATCH;
      if (func_ff == codes.response_code || func_ff == codes.voltage_code)
         csum_kind = KIND_VOLTAGE;
      else if (func_ff == codes.encoder_code)
         csum_kind = KIND_ENCODER;
      else
         csum_kind = KIND_OTHER;
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      sum_in   = sum_ff;
      func_in  = func_ff;
      data_in  = data_ff;
      emit     = 1'b0;
      result   = '0;
      case (phase_ff)
         PH_HDR2: begin
            if (rx_byte == HDR_SECOND)     phase_in = PH_LEN;
            else if (rx_byte != HDR_FIRST) phase_in = PH_HUNT;
         end
         PH_LEN: begin
            len_in  = rx_byte;
            seen_in = 8'd0;
            sum_in  = 8'd0;
            func_in = 8'd0;
            data_in = '0;
            if (rx_byte == 8'd0) begin
               phase_in         = PH_HUNT;
               emit             = 1'b1;
               result.status    = ST_SHORT;
               result.frame_len = 8'd0;
               result.kind      = KIND_OTHER;
            end else if (rx_byte == 8'd1) begin
               phase_in = PH_SHORT;
            end else begin
               phase_in = PH_BODY;
            end
         end
         PH_SHORT: begin
            phase_in         = PH_HUNT;
            emit             = 1'b1;
            result.status    = ST_SHORT;
            result.frame_len = len_ff;
            result.kind      = KIND_OTHER;
         end
         PH_BODY: begin
            if (seen_ff == 8'd0) func_in = rx_byte;
            else if (seen_ff <= 8'd4) data_in[seen_dec[1:0]] = rx_byte;
            sum_in  = sum_ff + rx_byte;
            seen_in = seen_ff + 8'd1;
            if (seen_plus2 >= {1'b0, len_ff}) phase_in = PH_CSUM;
         end
         PH_CSUM: begin
            phase_in         = PH_HUNT;
            emit             = 1'b1;
            result.status    = csum_status;
            result.func_code = func_ff;
            result.frame_len = len_ff;
            result.kind      = csum_kind;
            if (csum_status == ST_GOOD && csum_kind == KIND_VOLTAGE)
               result.voltage_mv = {data_ff[1], data_ff[0]};
            if (csum_status == ST_GOOD && csum_kind == KIND_ENCODER)
               result.enc = data_ff;
         end
         default: begin
            if (rx_byte == HDR_FIRST) phase_in = PH_HDR2;
            else                      phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= 8'd0;
         seen_ff  <= 8'd0;
         sum_ff   <= 8'd0;
         func_ff  <= 8'd0;
         data_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         sum_ff   <= sum_in;
         func_ff  <= func_in;
         data_ff  <= data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/sync_length_checksum_deframer.sv
// top level of the sync length checksum deframer
//
// req channel: one received byte per transfer (req_rx_byte). rsp channel: one
// transfer per finished frame with status, function code, length, kind and
// the decoded voltage or encoder fields; bytes that do not end a frame give
// no rsp transfer.
// A byte is taken into an input register, then handled by the frame state
// machine, whose result is loaded into the rsp register.
// rsp_valid rises once a frame's last byte has passed both registers.
// Throughput is one byte per cycle while the rsp receiver does not stall.
// A stalled rsp receiver holds the rsp register; the input register still
// takes one more byte, after which req_ready drops until the rsp transfer.
// The function codes are set through the APB port at addresses 0, 4 and 8
// and should only be changed while no frame is in flight.
// Synchronous reset empties both registers, returns the parser to header
// hunt and restores the code registers to 1, 2 and 3.
`default_nettype none
module sync_length_checksum_deframer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_rx_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_frame_status,
   output logic [7:0]                        rsp_func_code,
   output logic [7:0]                        rsp_frame_len,
   output logic [1:0]                        rsp_frame_kind,
   output logic [15:0]                       rsp_voltage_mv,
   output logic signed [7:0]                 rsp_enc_a,
   output logic signed [7:0]                 rsp_enc_b,
   output logic signed [7:0]                 rsp_enc_c,
   output logic signed [7:0]                 rsp_enc_d,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sldf_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready
);
   import sldf_pkg::*;

   codes_type  codes;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       emit;
   logic       step;

   sldf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .codes   (codes)
   );

   sldf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .codes   (codes),
      .emit    (emit),
      .result  (result)
   );

   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (step)              in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (step && emit)           rsp_ff     <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_ff.status;
   assign rsp_func_code    = rsp_ff.func_code;
   assign rsp_frame_len    = rsp_ff.frame_len;
   assign rsp_frame_kind   = rsp_ff.kind;
   assign rsp_voltage_mv   = rsp_ff.voltage_mv;
   assign rsp_enc_a        = $signed(rsp_ff.enc[0]);
   assign rsp_enc_b        = $signed(rsp_ff.enc[1]);
   assign rsp_enc_c        = $signed(rsp_ff.enc[2]);
   assign rsp_enc_d        = $signed(rsp_ff.enc[3]);

`ifndef ASSERT_OFF
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte lost while stalled");

   a_short_is_other: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == ST_SHORT |->
         rsp_frame_kind == KIND_OTHER && rsp_func_code == 8'd0)
      else $error("short frame reported with a function code");

   a_bad_no_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != ST_GOOD |->
         rsp_voltage_mv == 16'd0 && rsp_enc_a == 8'sd0 && rsp_enc_b == 8'sd0 &&
         rsp_enc_c == 8'sd0 && rsp_enc_d == 8'sd0)
      else $error("decoded fields set on a bad frame");

   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind != KIND_VOLTAGE |-> rsp_voltage_mv == 16'd0)
      else $error("voltage set for a non-voltage frame");
`endif

endmodule
`default_nettype wire

### verif/sldf_frame_checker.sv
// frame report checker for the sync length checksum deframer
`default_nettype none
module sldf_frame_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [1:0]                    rsp_frame_status,
   input  wire logic [7:0]                    rsp_func_code,
   input  wire logic [7:0]                    rsp_frame_len,
   input  wire logic [1:0]                    rsp_frame_kind,
   input  wire logic [15:0]                   rsp_voltage_mv,
   input  wire logic signed [7:0]             rsp_enc_a,
   input  wire logic signed [7:0]             rsp_enc_b,
   input  wire logic signed [7:0]             rsp_enc_c,
   input  wire logic signed [7:0]             rsp_enc_d,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [sldf_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   input  wire logic                          pready,
   output int                                 error_count,
   output int                                 frames_pending
);
   import sldf_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT, PH_HDR2, PH_LEN, PH_BODY, PH_CSUM, PH_SHORT
   } parse_phase_type;

   codes_type       codes;
   parse_phase_type phase;
   logic [7:0]      len_q;
   logic [7:0]      count_q;
   logic [7:0]      sum_q;
   logic [7:0]      func_q;
   logic [3:0][7:0] data_q;
   result_type      expected_frames[$];

   task automatic post_frame(input status_type st, input logic [7:0] func,
                             input logic [7:0] len, input kind_type kind,
                             input bit decode);
      result_type r;
      r = '0;
      r.status    = st;
      r.func_code = func;
      r.frame_len = len;
      r.kind      = kind;
      if (decode && kind == KIND_VOLTAGE) r.voltage_mv = {data_q[1], data_q[0]};
      if (decode && kind == KIND_ENCODER) r.enc = data_q;
      expected_frames.insert(expected_frames.size(), r);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      status_type st;
      kind_type   kind;
      case (phase)
         PH_HDR2: begin
            if (b == HDR_SECOND) phase = PH_LEN;
            else if (b != HDR_FIRST) phase = PH_HUNT;
         end
         PH_LEN: begin
            len_q   = b;
            count_q = '0;
            sum_q   = '0;
            func_q  = '0;
            data_q  = '0;
            if (b == 8'd0) begin
               phase = PH_HUNT;
               post_frame(ST_SHORT, 8'd0, 8'd0, KIND_OTHER, 1'b0);
            end else begin
               phase = (b == 8'd1) ? PH_SHORT : PH_BODY;
            end
         end
         PH_SHORT: begin
            phase = PH_HUNT;
            post_frame(ST_SHORT, 8'd0, len_q, KIND_OTHER, 1'b0);
         end
         PH_BODY: begin
            if (count_q == 8'd0) func_q = b;
            else if (count_q <= 8'd4) data_q[count_q[1:0] - 2'd1] = b;
            sum_q   = sum_q + b;
            count_q = count_q + 8'd1;
            if ({1'b0, count_q} + 9'd1 >= {1'b0, len_q}) phase = PH_CSUM;
         end
         PH_CSUM: begin
            st = (b == sum_q) ? ST_GOOD : ST_MISMATCH;
            if (func_q == codes.response_code || func_q == codes.voltage_code)
               kind = KIND_VOLTAGE;
            else if (func_q == codes.encoder_code)
               kind = KIND_ENCODER;
            else
               kind = KIND_OTHER;
            phase = PH_HUNT;
            post_frame(st, func_q, len_q, kind, st == ST_GOOD);
         end
         default: phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         codes.response_code = RESET_RESPONSE_CODE;
         codes.voltage_code  = RESET_VOLTAGE_CODE;
         codes.encoder_code  = RESET_ENCODER_CODE;
         phase       = PH_HUNT;
         len_q       = '0;
         count_q     = '0;
         sum_q       = '0;
         func_q      = '0;
         data_q      = '0;
         error_count = 0;
         expected_frames.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[ADDR_W-1:2]))
               REG_RESPONSE: codes.response_code = pwdata[7:0];
               REG_VOLTAGE:  codes.voltage_code  = pwdata[7:0];
               REG_ENCODER:  codes.encoder_code  = pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               error_count++;
               $display("%0t: unexpected rsp transfer, expected none, actual func %0h len %0h",
                        $time, rsp_func_code, rsp_frame_len);
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_status", 16'(want.status), 16'(rsp_frame_status));
               check_field("func_code", 16'(want.func_code), 16'(rsp_func_code));
               check_field("frame_len", 16'(want.frame_len), 16'(rsp_frame_len));
               check_field("frame_kind", 16'(want.kind), 16'(rsp_frame_kind));
               check_field("voltage_mv", want.voltage_mv, rsp_voltage_mv);
               check_field("enc_a", 16'(want.enc[0]), 16'($unsigned(rsp_enc_a)));
               check_field("enc_b", 16'(want.enc[1]), 16'($unsigned(rsp_enc_b)));
               check_field("enc_c", 16'(want.enc[2]), 16'($unsigned(rsp_enc_c)));
               check_field("enc_d", 16'(want.enc[3]), 16'($unsigned(rsp_enc_d)));
            end
         end
         if (req_valid && req_ready) parse_byte(req_rx_byte);
      end
      frames_pending = expected_frames.size();
   end

endmodule
`default_nettype wire

### verif/sync_length_checksum_deframer_tb.sv
// testbench top for the sync length checksum deframer
`default_nettype none
module sync_length_checksum_deframer_tb;
   import sldf_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 1750;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 4;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_frame_status;
   logic [7:0]            rsp_func_code;
   logic [7:0]            rsp_frame_len;
   logic [1:0]            rsp_frame_kind;
   logic [15:0]           rsp_voltage_mv;
   logic signed [7:0]     rsp_enc_a;
   logic signed [7:0]     rsp_enc_b;
   logic signed [7:0]     rsp_enc_c;
   logic signed [7:0]     rsp_enc_d;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_W-1:0]     paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    error_count;
   int                    frames_pending;

   codes_type             stim_codes;
   bit                    sender_busy;
   int                    stim_bytes;

   sync_length_checksum_deframer dut (.*);

   sldf_frame_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(8 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_busy ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(0, 39) == 0) sender_busy = !sender_busy;
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_frame();
      logic [7:0] len;
      logic [7:0] func;
      logic [7:0] sum;
      logic [7:0] b;
      int         n;
      case ($urandom_range(0, 39))
         0: len = 8'd0;
         1: len = 8'd1;
         2: len = 8'($urandom_range(9, 254));
         3: len = 8'd255;
         default: len = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
         0: func = stim_codes.response_code;
         1: func = stim_codes.voltage_code;
         2, 3: func = stim_codes.encoder_code;
         default: func = pick_data();
      endcase
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(len);
      if (len == 8'd1) begin
         send_byte(pick_data());
      end else if (len >= 8'd2) begin
         sum = func;
         send_byte(func);
         for (n = 2; n < len; n++) begin
            b = pick_data();
            sum = sum + b;
            send_byte(b);
         end
         send_byte(($urandom_range(0, 4) == 0) ? pick_data() : sum);
      end
      stim_bytes += len + 3;
   endtask

   // no header pair inside noise, so the parser is never left inside a frame
   task automatic send_noise();
      logic [7:0] prev;
      logic [7:0] b;
      int         n;
      prev = 8'h00;
      for (n = $urandom_range(1, 4); n > 0; n--) begin
         b = ($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom);
         if ((prev == HDR_FIRST && b == HDR_SECOND) || (n == 1 && b == HDR_FIRST))
            b = 8'h00;
         send_byte(b);
         stim_bytes++;
         prev = b;
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [7:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_RESPONSE: stim_codes.response_code = v;
         REG_VOLTAGE:  stim_codes.voltage_code  = v;
         REG_ENCODER:  stim_codes.encoder_code  = v;
         default: ;
      endcase
   endtask

   initial begin
      int         stall;
      bit         busy;
      int         got;
      rsp_ready <= 1'b0;
      busy = 1'b0;
      got  = 0;
      do @(posedge clock); while (reset);
      forever begin
         stall = busy ? 0 : $urandom_range(0, 5);
         if (got == 20) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got++;
         if ($urandom_range(0, 29) == 0) busy = !busy;
      end
   end

   initial begin
      logic [7:0] directed[25];
      logic [7:0] r;
      int         phase;
      int         n;
      directed = '{8'hFF, 8'hCC, 8'h00,
                   8'hFF, 8'h12, 8'hFF, 8'hFF, 8'hCC, 8'h01, 8'h55,
                   8'hFF, 8'hCC, 8'h06, 8'h03, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01,
                   8'hFF, 8'hCC, 8'h03, 8'h02, 8'hFF, 8'h01};
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      stim_codes.response_code = RESET_RESPONSE_CODE;
      stim_codes.voltage_code  = RESET_VOLTAGE_CODE;
      stim_codes.encoder_code  = RESET_ENCODER_CODE;
      sender_busy = 1'b0;
      stim_bytes  = 0;
      do @(posedge clock); while (reset);

      foreach (directed[i]) send_byte(directed[i]);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               write_reg(REG_RESPONSE, 8'h00);
               write_reg(REG_VOLTAGE, 8'hFF);
               write_reg(REG_ENCODER, 8'h00);
               write_reg(REG_NONE, 8'h5A);
            end
            2: begin
               write_reg(REG_RESPONSE, 8'hFF);
               write_reg(REG_VOLTAGE, 8'h00);
               write_reg(REG_ENCODER, 8'hFF);
            end
            3: begin
               r = 8'($urandom);
               write_reg(REG_RESPONSE, 8'($urandom));
               write_reg(REG_VOLTAGE, r);
               write_reg(REG_ENCODER, r);
            end
            default: ;
         endcase
         while (stim_bytes < (phase + 1) * RANDOM_BYTES / PHASES) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_frame();
         end
      end

      req_valid <= 1'b0;
      for (n = 0; n < 20000 && frames_pending != 0; n++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && frames_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

### sync_length_checksum_deframer.f
rtl/sldf_pkg.sv
rtl/sldf_csr.sv
rtl/sldf_parser.sv
rtl/sync_length_checksum_deframer.sv
verif/sldf_frame_checker.sv
verif/sync_length_checksum_deframer_tb.sv
